FILE: sv/nmsl_pkg.sv
// shared types, request codes and constants of the nearest match sorted list
// depends on nothing
package nmsl_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int ID_W          = 16;
   localparam int DIST_W        = 16;

   localparam logic [ID_W-1:0]   ID_EMPTY      = '1;
   localparam logic [DIST_W-1:0] DIST_SENTINEL = '1;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_CLEAR  = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   // what every cell sees of the current request
   typedef struct packed {
      logic              insert;
      logic              clear;
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] distance;
   } cmd_type;

   // what one cell hands to its right neighbor
   typedef struct packed {
      logic              gt;
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] distance;
   } link_type;

endpackage

FILE: sv/nmsl_cell.sv
// one slot of the sorted list: holds an id and a distance, compares and shifts
// depends on nmsl_pkg
module nmsl_cell import nmsl_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int K     = 0,
   localparam int CW   = $clog2(SLOTS)
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic [CW-1:0] count,
   input  link_type      prev,
   output link_type      next,
   output logic          is_pos
);

   logic [ID_W-1:0]   id_ff, id_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              gt;

   // new pair goes further right than this slot
   assign gt = (CW'(K) < count) && (cmd.distance > dist_ff);
   assign is_pos = cmd.insert && !gt && prev.gt;

   always_comb begin
      id_in   = id_ff;
      dist_in = dist_ff;
      if (cmd.clear) begin
         id_in   = ID_EMPTY;
         dist_in = DIST_SENTINEL;
      end else if (cmd.insert && !gt) begin
         if (prev.gt) begin
            id_in   = cmd.id;
            dist_in = cmd.distance;
         end else if (CW'(K) <= count) begin
            id_in   = prev.id;
            dist_in = prev.distance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff   <= ID_EMPTY;
         dist_ff <= DIST_SENTINEL;
      end else begin
         id_ff   <= id_in;
         dist_ff <= dist_in;
      end
   end

   assign next.gt       = gt;
   assign next.id       = id_ff;
   assign next.distance = dist_ff;

endmodule

FILE: sv/nearest_match_sorted_list_unit.sv
// top level of the nearest match sorted list: chain of slot cells and result register
// depends on nmsl_pkg and nmsl_cell
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  request | req_valid req_stall req_type req_obj_id        | in
//          | req_distance req_read_index                   |
//  result  | rsp_valid rsp_stall rsp_match_count            | out
//          | rsp_insert_slot rsp_entry_id rsp_entry_distance |
//          | rsp_entry_valid                               |
//
// one request per cycle while req_stall is low; the result shows in the cycle after acceptance
// on an insert every cell compares against the new distance
// in parallel and takes either its own, the new or its left neighbor's pair
// reset fills every slot with the sentinel and empties the list
// req_stall is high only while a result waits and rsp_stall holds it
module nearest_match_sorted_list_unit import nmsl_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [ID_W-1:0]   req_obj_id,
   input  logic [DIST_W-1:0] req_distance,
   input  logic [2:0]        req_read_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_match_count,
   output logic [2:0]        rsp_insert_slot,
   output logic [ID_W-1:0]   rsp_entry_id,
   output logic [DIST_W-1:0] rsp_entry_distance,
   output logic              rsp_entry_valid
);

   localparam int CW = $clog2(SLOTS);
   localparam int RD = (SLOTS < 8) ? SLOTS : 8;   // slots reachable by read_index

   logic              accept;
   cmd_type           cmd;
   link_type          link [SLOTS+1];
   logic [SLOTS-1:0]  is_pos;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     pos;
   logic [CW+2:0]     count_ext, pos_ext;

   // result register
   logic              valid_ff, valid_in;
   logic [2:0]        mcount_ff, mcount_in;
   logic [2:0]        islot_ff, islot_in;
   logic [ID_W-1:0]   eid_ff, eid_in;
   logic [DIST_W-1:0] edist_ff, edist_in;
   logic              evalid_ff, evalid_in;

   // readout of a slot for a read request
   logic [ID_W-1:0]   rd_id;
   logic [DIST_W-1:0] rd_dist;

   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign cmd.insert   = accept && (req_type == REQ_INSERT);
   assign cmd.clear    = accept && (req_type == REQ_CLEAR);
   assign cmd.id       = req_obj_id;
   assign cmd.distance = req_distance;

   // head of the chain: slot zero always may take the new pair
   assign link[0].gt       = 1'b1;
   assign link[0].id       = req_obj_id;
   assign link[0].distance = req_distance;

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      nmsl_cell #(.SLOTS(SLOTS), .K(k)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cmd),
         .count  (count_ff),
         .prev   (link[k]),
         .next   (link[k+1]),
         .is_pos (is_pos[k])
      );
   end

   // one-hot insert position to index
   always_comb begin
      pos = '0;
      for (int k = 0; k < SLOTS; k++) begin
         if (is_pos[k]) pos = pos | CW'(k);
      end
   end

   // visible count saturates one below the slot count
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.insert && (count_ff != CW'(SLOTS - 1))) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      rd_id   = '0;
      rd_dist = '0;
      for (int j = 0; j < RD; j++) begin
         if (req_read_index == 3'(j)) begin
            rd_id   = link[j+1].id;
            rd_dist = link[j+1].distance;
         end
      end
   end

   assign count_ext = {3'b000, count_in};
   assign pos_ext   = {3'b000, pos};

   always_comb begin
      mcount_in = count_ext[2:0];
      islot_in  = '0;
      eid_in    = rd_id;
      edist_in  = rd_dist;
      evalid_in = {29'd0, req_read_index} < {{(32-CW){1'b0}}, count_ff};
      if (cmd.clear) begin
         eid_in    = ID_EMPTY;
         edist_in  = DIST_SENTINEL;
         evalid_in = 1'b0;
      end else if (cmd.insert) begin
         islot_in  = pos_ext[2:0];
         // slot zero after the insert
         eid_in    = is_pos[0] ? req_obj_id   : link[1].id;
         edist_in  = is_pos[0] ? req_distance : link[1].distance;
         evalid_in = 1'b1;
      end
   end

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (accept) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // result payload, loaded with each accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         mcount_ff <= mcount_in;
         islot_ff  <= islot_in;
         eid_ff    <= eid_in;
         edist_ff  <= edist_in;
         evalid_ff <= evalid_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_match_count    = mcount_ff;
   assign rsp_insert_slot    = islot_ff;
   assign rsp_entry_id       = eid_ff;
   assign rsp_entry_distance = edist_ff;
   assign rsp_entry_valid    = evalid_ff;

   // count never reaches the hidden slot
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS - 1))
      else $error("visible count beyond last visible slot");

   // an insert lands in exactly one cell
   a_pos_onehot: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> $onehot(is_pos))
      else $error("insert position not unique");

   // a clear empties the list
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0) && (link[1].distance == DIST_SENTINEL))
      else $error("list not empty after clear");

   // a result only appears after an accepted request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !$past(valid_ff)) |-> $past(accept))
      else $error("result without request");

endmodule

FILE: bench/testbench.sv
// self-checking bench for nearest_match_sorted_list_unit: directed and random requests
// depends on nmsl_pkg and the unit's rtl; predicts each result from its own copy of the list
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import nmsl_pkg::*;

   localparam int SLOTS = SLOTS_DEFAULT;
   // the fourth request code is unused; the block answers it like a read
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_PER_PHASE = 500;
   localparam int WATCHDOG_LIMIT = 4000;
   // result shows in the cycle after acceptance; the drain waits longer for margin
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      logic [1:0]        kind;
      logic [ID_W-1:0]   obj_id;
      logic [DIST_W-1:0] distance;
      logic [2:0]        read_index;
   } list_request_type;

   typedef struct {
      logic [2:0]        count;
      logic [2:0]        slot;
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] distance;
      logic              valid;
   } list_report_type;

   // every input known from time zero
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_type = REQ_READ;
   logic [ID_W-1:0]   req_obj_id = '0;
   logic [DIST_W-1:0] req_distance = '0;
   logic [2:0]        req_read_index = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_match_count;
   logic [2:0]        rsp_insert_slot;
   logic [ID_W-1:0]   rsp_entry_id;
   logic [DIST_W-1:0] rsp_entry_distance;
   logic              rsp_entry_valid;

   // own copy of the sorted list
   logic [ID_W-1:0]   list_ids [SLOTS];
   logic [DIST_W-1:0] list_dists [SLOTS];
   int                list_len;

   list_request_type pending_requests[$];
   list_report_type  reports_due[$];
   list_request_type next_request;
   list_report_type  due_report;

   int sender_idle_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int idle_cycles = 0;

   nearest_match_sorted_list_unit #(.SLOTS(SLOTS)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_obj_id         (req_obj_id),
      .req_distance       (req_distance),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_match_count    (rsp_match_count),
      .rsp_insert_slot    (rsp_insert_slot),
      .rsp_entry_id       (rsp_entry_id),
      .rsp_entry_distance (rsp_entry_distance),
      .rsp_entry_valid    (rsp_entry_valid)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // applies one request to the list copy and returns the result it should give
   function automatic list_report_type apply_list_request(logic [1:0] kind,
                                                          logic [ID_W-1:0] id,
                                                          logic [DIST_W-1:0] pair_dist,
                                                          logic [2:0] read_index);
      list_report_type rep;
      int pos;
      int shown;
      int n;
      pos = 0;
      shown = 0;
      if (kind == REQ_INSERT) begin
         n = (list_len > SLOTS - 1) ? SLOTS - 1 : list_len;
         // new pair goes before the first entry with a distance not smaller
         while (pos < n && pair_dist > list_dists[pos])
            pos++;
         // on a full list the last visible entry shifts into the hidden slot
         for (int k = n; k > pos; k--) begin
            list_ids[k] = list_ids[k-1];
            list_dists[k] = list_dists[k-1];
         end
         list_ids[pos] = id;
         list_dists[pos] = pair_dist;
         n++;
         list_len = (n >= SLOTS) ? SLOTS - 1 : n;
      end else if (kind == REQ_CLEAR) begin
         for (int k = 0; k < SLOTS; k++) begin
            list_ids[k] = ID_EMPTY;
            list_dists[k] = DIST_SENTINEL;
         end
         list_len = 0;
      end else begin
         shown = int'(read_index);
      end
      rep.count = 3'(list_len);
      rep.slot = 3'(pos);
      // indexes past the last slot report zeros
      if (shown < SLOTS) begin
         rep.id = list_ids[shown];
         rep.distance = list_dists[shown];
         rep.valid = (shown < list_len);
      end else begin
         rep.id = '0;
         rep.distance = '0;
         rep.valid = 1'b0;
      end
      return rep;
   endfunction

   task automatic push_request(logic [1:0] kind, logic [ID_W-1:0] id,
                               logic [DIST_W-1:0] pair_dist, logic [2:0] read_index);
      list_request_type rq;
      rq.kind = kind;
      rq.obj_id = id;
      rq.distance = pair_dist;
      rq.read_index = read_index;
      pending_requests.push_back(rq);
   endtask

   // mostly inserts so the list fills up and overflows between the rare clears
   function automatic list_request_type random_request();
      list_request_type rq;
      int pick;
      rq.obj_id = 16'($urandom);
      rq.distance = 16'($urandom);
      rq.read_index = 3'($urandom_range(7));
      pick = int'($urandom_range(99));
      if (pick < 3)
         rq.kind = REQ_CLEAR;
      else if (pick < 5)
         rq.kind = REQ_UNUSED;
      else if (pick < 30)
         rq.kind = REQ_READ;
      else
         rq.kind = REQ_INSERT;
      // shape distances: narrow range for ties, extremes, small q8.8 values
      case ($urandom_range(3))
         0: rq.distance = 16'($urandom_range(7));
         1: begin
            pick = int'($urandom_range(2));
            rq.distance = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'h8000;
         end
         2: rq.distance = 16'($urandom_range(16'h0800));
         default: ;
      endcase
      return rq;
   endfunction

   task automatic report_field(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endtask

   task automatic run_phase(int idle, int stall);
      @(negedge clock);
      sender_idle_pct = idle;
      stall_pct = stall;
      repeat (RANDOM_PER_PHASE)
         pending_requests.push_back(random_request());
      while (pending_requests.size() != 0 || req_valid || reports_due.size() != 0)
         @(negedge clock);
   endtask

   // driver: predicts on each accepted request, then offers the next one or idles
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            reports_due.push_back(apply_list_request(req_type, req_obj_id, req_distance,
                                                     req_read_index));
         // a stalled request holds its payload and valid
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_request = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_type <= next_request.kind;
               req_obj_id <= next_request.obj_id;
               req_distance <= next_request.distance;
               req_read_index <= next_request.read_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // monitor: every accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reports_due.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, got count %0d slot %0d id %h dist %h valid %b",
                     $time, rsp_match_count, rsp_insert_slot, rsp_entry_id,
                     rsp_entry_distance, rsp_entry_valid);
         end else begin
            due_report = reports_due.pop_front();
            report_field("match_count", 16'(due_report.count), 16'(rsp_match_count));
            report_field("insert_slot", 16'(due_report.slot), 16'(rsp_insert_slot));
            report_field("entry_id", due_report.id, rsp_entry_id);
            report_field("entry_distance", due_report.distance, rsp_entry_distance);
            report_field("entry_valid", 16'(due_report.valid), 16'(rsp_entry_valid));
         end
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // list copy starts empty, as after reset
      for (int k = 0; k < SLOTS; k++) begin
         list_ids[k] = ID_EMPTY;
         list_dists[k] = DIST_SENTINEL;
      end
      list_len = 0;

      // directed: empty list, ties, filling, overflow into the hidden slot, every slot read
      push_request(REQ_CLEAR, 16'h1234, 16'h5678, 3'd0);
      push_request(REQ_READ, 16'hFFFF, 16'hFFFF, 3'd0);
      push_request(REQ_INSERT, 16'h0001, 16'h0100, 3'd7);
      push_request(REQ_INSERT, 16'h0002, 16'h0080, 3'd0);
      // equal distance goes ahead of the existing entry
      push_request(REQ_INSERT, 16'h0003, 16'h0100, 3'd0);
      push_request(REQ_INSERT, 16'hFFFF, 16'hFFFF, 3'd0);
      push_request(REQ_INSERT, 16'h0000, 16'h0000, 3'd0);
      push_request(REQ_INSERT, 16'h0005, 16'h0200, 3'd0);
      push_request(REQ_INSERT, 16'h0006, 16'h0300, 3'd0);
      // list full: largest pair falls into the hidden slot
      push_request(REQ_INSERT, 16'hA5A5, 16'h0050, 3'd0);
      push_request(REQ_INSERT, 16'h5A5A, 16'hFFFF, 3'd0);
      for (int k = 0; k < 8; k++)
         push_request(REQ_READ, 16'(k), 16'hFFFF - 16'(k), 3'(k));
      push_request(REQ_UNUSED, 16'hBEEF, 16'h0001, 3'd5);
      push_request(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 3'd7);
      push_request(REQ_READ, 16'h0000, 16'h0000, 3'd7);
      push_request(REQ_READ, 16'h0000, 16'h0000, 3'd0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // no idling, then sender gaps, then receiver stalls, then a little of both
      run_phase(0, 0);
      run_phase(86, 0);
      run_phase(0, 86);
      run_phase(24, 24);

      // let any stray result show up before deciding
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: files.f
sv/nmsl_pkg.sv
sv/nmsl_cell.sv
sv/nearest_match_sorted_list_unit.sv
bench/testbench.sv
